@@ rtl/split_only_buddy_allocator_macros.svh @@
// assertion macros used by the allocator top level
`ifndef SPLIT_ONLY_BUDDY_ALLOCATOR_MACROS_SVH
`define SPLIT_ONLY_BUDDY_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define SBA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sba_pkg.sv @@
// shared types and constants of the split-only buddy allocator
package sba_pkg;

  localparam int REQ_W  = 17;
  localparam int ADDR_W = 14;
  localparam int SC_W   = 5;
  localparam int CLS_W  = 4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOMEM     = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_e;

  typedef struct packed {
    status_e            status;
    logic [ADDR_W-1:0]  gaddr;
    logic [SC_W-1:0]    sclass;
    logic               released;
  } res_t;

  typedef struct packed {
    logic             too_large;
    logic             hit;
    logic [CLS_W-1:0] hit_k;
    logic [CLS_W-1:0] req_k;
  } srch_t;

  typedef struct packed {
    logic link;
    logic cls;
    logic sbi;
    logic alloc;
  } amask_t;

  typedef struct packed {
    logic bytes;
    logic idle;
  } bmask_t;

endpackage

@@ rtl/split_only_buddy_allocator.sv @@
// top level: sequencer, minblock and superblock memories of the buddy allocator
//
// channel | direction | handshake              | beat
// in      | input     | in_valid_i / in_stall_o   | mode, request_bytes, block_address
// out     | output    | out_valid_o / out_stall_i | status, granted_address, size_class,
//         |           |                           | superblock_released
//
// after reset a clearing pass over every minblock and superblock entry, no beat taken
// allocate runs search, pop or claim (neither on a fresh superblock), split steps and
// accounting; too large or out of memory ends after search; free runs read, check and
// accounting; emptying a superblock adds a purge walk of every class list, then the
// idle push, serial through the single read port of the minblock memory
// a finished result sits in the output register so the next beat can be taken
`include "split_only_buddy_allocator_macros.svh"
module split_only_buddy_allocator import sba_pkg::*; #(
  parameter int SUPERBLOCKS              = 16,
  parameter int MINBLOCKS_PER_SUPERBLOCK = 1024,
  parameter int MINBLOCK_BYTES           = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              mode_i,
  input  logic [REQ_W-1:0]  request_bytes_i,
  input  logic [ADDR_W-1:0] block_address_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [ADDR_W-1:0] granted_address_o,
  output logic [SC_W-1:0]   size_class_o,
  output logic              superblock_released_o
);

  localparam int TOTAL  = SUPERBLOCKS * MINBLOCKS_PER_SUPERBLOCK;
  localparam int IW     = $clog2(TOTAL);
  localparam int LW     = $clog2(TOTAL + 1);
  localparam int KMAX   = $clog2(MINBLOCKS_PER_SUPERBLOCK + 1) - 1;
  localparam int KIW    = $clog2(KMAX + 1);
  localparam int MINLOG = $clog2(MINBLOCK_BYTES + 1) - 1;
  localparam int SBW    = (SUPERBLOCKS > 1) ? $clog2(SUPERBLOCKS) : 1;
  localparam int CW     = $clog2(SUPERBLOCKS + 1);
  localparam int BUW    = $clog2((MINBLOCK_BYTES << KMAX) + 1);
  localparam logic [LW-1:0] NIL = LW'(TOTAL);

  localparam logic [3:0] S_CLEAR      = 4'd0;
  localparam logic [3:0] S_IDLE       = 4'd1;
  localparam logic [3:0] S_SEARCH     = 4'd2;
  localparam logic [3:0] S_POP        = 4'd3;
  localparam logic [3:0] S_CLAIM      = 4'd4;
  localparam logic [3:0] S_SPLIT      = 4'd5;
  localparam logic [3:0] S_ACCT       = 4'd6;
  localparam logic [3:0] S_FREE_RD    = 4'd7;
  localparam logic [3:0] S_FREE_CHK   = 4'd8;
  localparam logic [3:0] S_FREE_ACCT  = 4'd9;
  localparam logic [3:0] S_PURGE_HEAD = 4'd10;
  localparam logic [3:0] S_PURGE_RD   = 4'd11;
  localparam logic [3:0] S_IDLE_PUSH  = 4'd12;
  localparam logic [3:0] S_DONE       = 4'd13;

  typedef struct packed {
    logic [LW-1:0]    link;
    logic [CLS_W-1:0] cls;
    logic [SBW-1:0]   sbi;
    logic             alloc;
  } aent_t;

  typedef struct packed {
    logic [BUW-1:0] bytes;
    logic [SBW-1:0] idle;
  } bent_t;

  function automatic logic [BUW-1:0] cbytes(input logic [CLS_W-1:0] k);
    return BUW'(MINBLOCK_BYTES) << k;
  endfunction

  logic [3:0]        state_q, state_d;
  logic [REQ_W-1:0]  req_q, req_d;
  logic [ADDR_W-1:0] baddr_q, baddr_d;
  logic [IW-1:0]     addr_q, addr_d;
  logic [CLS_W-1:0]  k_q, k_d;
  logic [CLS_W-1:0]  reqk_q, reqk_d;
  logic [CLS_W-1:0]  pk_q, pk_d;
  logic [SBW-1:0]    sb_q, sb_d;
  logic [LW-1:0]     cur_q, cur_d;
  logic [LW-1:0]     prev_q, prev_d;
  logic [LW-1:0]     head_q [KMAX+1];
  logic [LW-1:0]     head_d [KMAX+1];
  logic [CW-1:0]     idle_cnt_q, idle_cnt_d;
  logic [CW-1:0]     fresh_cnt_q, fresh_cnt_d;
  logic [IW-1:0]     clr_q, clr_d;
  res_t              res_q, res_d;

  aent_t         mema [TOTAL];
  aent_t         a_rdata_q, a_wdata;
  amask_t        a_we;
  logic [IW-1:0] a_waddr, a_raddr;

  bent_t          memb [SUPERBLOCKS];
  bent_t          b_rdata_q, b_wdata;
  bmask_t         b_we;
  logic [SBW-1:0] b_waddr, b_raddr;

  logic [KMAX:0] nonempty;
  srch_t         srch;
  logic          out_ready, out_load;
  res_t          out_res;
  logic [CLS_W-1:0] nk;
  logic [IW-1:0]    buddy;
  logic [BUW-1:0]   nb;
  logic [LW-1:0]    nxt;

  always_comb begin
    for (int k = 0; k <= KMAX; k++) begin
      nonempty[k] = head_q[k] != NIL;
    end
  end

  sba_search #(
    .KMAX          (KMAX),
    .MINBLOCK_BYTES(MINBLOCK_BYTES)
  ) u_search (
    .req_i     (req_q),
    .nonempty_i(nonempty),
    .srch_o    (srch)
  );

  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    baddr_d     = baddr_q;
    addr_d      = addr_q;
    k_d         = k_q;
    reqk_d      = reqk_q;
    pk_d        = pk_q;
    sb_d        = sb_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    head_d      = head_q;
    idle_cnt_d  = idle_cnt_q;
    fresh_cnt_d = fresh_cnt_q;
    clr_d       = clr_q;
    res_d       = res_q;
    a_we        = '0;
    a_waddr     = '0;
    a_wdata     = '0;
    a_raddr     = '0;
    b_we        = '0;
    b_waddr     = '0;
    b_wdata     = '0;
    b_raddr     = '0;
    out_load    = 1'b0;
    nk          = k_q - 1'b1;
    buddy       = addr_q + (IW'(1) << nk);
    nb          = (b_rdata_q.bytes >= cbytes(k_q)) ? b_rdata_q.bytes - cbytes(k_q) : '0;
    nxt         = a_rdata_q.link;
    case (state_q)
      S_CLEAR: begin
        a_we.alloc    = 1'b1;
        a_waddr       = clr_q;
        a_wdata.alloc = 1'b0;
        if (32'(clr_q) < SUPERBLOCKS) begin
          b_we.bytes    = 1'b1;
          b_waddr       = SBW'(clr_q);
          b_wdata.bytes = '0;
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == IW'(TOTAL - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = request_bytes_i;
          baddr_d = block_address_i;
          res_d   = '0;
          state_d = mode_i ? S_FREE_RD : S_SEARCH;
        end
      end
      S_SEARCH: begin
        reqk_d = srch.req_k;
        if (srch.too_large) begin
          res_d.status = ST_TOO_LARGE;
          state_d      = S_DONE;
        end else if (srch.hit) begin
          k_d     = srch.hit_k;
          addr_d  = IW'(head_q[KIW'(srch.hit_k)]);
          a_raddr = IW'(head_q[KIW'(srch.hit_k)]);
          state_d = S_POP;
        end else if (idle_cnt_q != '0) begin
          b_raddr = SBW'(idle_cnt_q - 1'b1);
          state_d = S_CLAIM;
        end else if (fresh_cnt_q < CW'(SUPERBLOCKS)) begin
          sb_d        = SBW'(fresh_cnt_q);
          addr_d      = IW'(fresh_cnt_q) * IW'(MINBLOCKS_PER_SUPERBLOCK);
          k_d         = CLS_W'(KMAX);
          fresh_cnt_d = fresh_cnt_q + 1'b1;
          state_d     = S_SPLIT;
        end else begin
          res_d.status = ST_NOMEM;
          state_d      = S_DONE;
        end
      end
      S_POP: begin
        head_d[KIW'(k_q)] = a_rdata_q.link;
        sb_d              = a_rdata_q.sbi;
        state_d           = S_SPLIT;
      end
      S_CLAIM: begin
        sb_d       = b_rdata_q.idle;
        addr_d     = IW'(b_rdata_q.idle) * IW'(MINBLOCKS_PER_SUPERBLOCK);
        idle_cnt_d = idle_cnt_q - 1'b1;
        k_d        = CLS_W'(KMAX);
        state_d    = S_SPLIT;
      end
      S_SPLIT: begin
        if (k_q > reqk_q) begin
          a_we.link          = 1'b1;
          a_we.sbi           = 1'b1;
          a_waddr            = buddy;
          a_wdata.link       = head_q[KIW'(nk)];
          a_wdata.sbi        = sb_q;
          head_d[KIW'(nk)]   = LW'(buddy);
          k_d                = nk;
        end else begin
          a_we.cls      = 1'b1;
          a_we.sbi      = 1'b1;
          a_we.alloc    = 1'b1;
          a_waddr       = addr_q;
          a_wdata.cls   = k_q;
          a_wdata.sbi   = sb_q;
          a_wdata.alloc = 1'b1;
          b_raddr       = sb_q;
          state_d       = S_ACCT;
        end
      end
      S_ACCT: begin
        b_we.bytes    = 1'b1;
        b_waddr       = sb_q;
        b_wdata.bytes = b_rdata_q.bytes + cbytes(k_q);
        res_d.status  = ST_OK;
        res_d.gaddr   = ADDR_W'(addr_q);
        res_d.sclass  = SC_W'(MINLOG) + SC_W'(k_q);
        state_d       = S_DONE;
      end
      S_FREE_RD: begin
        if (32'(baddr_q) >= TOTAL) begin
          res_d.status = ST_BAD_FREE;
          state_d      = S_DONE;
        end else begin
          a_raddr = IW'(baddr_q);
          state_d = S_FREE_CHK;
        end
      end
      S_FREE_CHK: begin
        if (!a_rdata_q.alloc) begin
          res_d.status = ST_BAD_FREE;
          state_d      = S_DONE;
        end else begin
          k_d           = a_rdata_q.cls;
          sb_d          = a_rdata_q.sbi;
          a_we.link     = 1'b1;
          a_we.alloc    = 1'b1;
          a_waddr       = IW'(baddr_q);
          a_wdata.link  = head_q[KIW'(a_rdata_q.cls)];
          a_wdata.alloc = 1'b0;
          head_d[KIW'(a_rdata_q.cls)] = LW'(baddr_q);
          b_raddr       = a_rdata_q.sbi;
          state_d       = S_FREE_ACCT;
        end
      end
      S_FREE_ACCT: begin
        b_we.bytes    = 1'b1;
        b_waddr       = sb_q;
        b_wdata.bytes = nb;
        res_d.status  = ST_OK;
        res_d.sclass  = SC_W'(MINLOG) + SC_W'(k_q);
        if (nb == '0) begin
          pk_d    = '0;
          cur_d   = head_q[0];
          prev_d  = NIL;
          state_d = S_PURGE_HEAD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_PURGE_HEAD: begin
        if (cur_q >= NIL) begin
          if (pk_q == CLS_W'(KMAX)) begin
            state_d = S_IDLE_PUSH;
          end else begin
            pk_d   = pk_q + 1'b1;
            cur_d  = head_q[KIW'(pk_q + 1'b1)];
            prev_d = NIL;
          end
        end else begin
          a_raddr = IW'(cur_q);
          state_d = S_PURGE_RD;
        end
      end
      S_PURGE_RD: begin
        if (a_rdata_q.sbi == sb_q) begin
          if (prev_q == NIL) begin
            head_d[KIW'(pk_q)] = nxt;
          end else begin
            a_we.link    = 1'b1;
            a_waddr      = IW'(prev_q);
            a_wdata.link = nxt;
          end
        end else begin
          prev_d = cur_q;
        end
        cur_d = nxt;
        if (nxt < NIL) begin
          a_raddr = IW'(nxt);
        end else begin
          state_d = S_PURGE_HEAD;
        end
      end
      S_IDLE_PUSH: begin
        if (idle_cnt_q < CW'(SUPERBLOCKS)) begin
          b_we.idle    = 1'b1;
          b_waddr      = SBW'(idle_cnt_q);
          b_wdata.idle = sb_q;
          idle_cnt_d   = idle_cnt_q + 1'b1;
        end
        res_d.released = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (out_ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      idle_cnt_q  <= '0;
      fresh_cnt_q <= '0;
      for (int k = 0; k <= KMAX; k++) begin
        head_q[k] <= NIL;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      idle_cnt_q  <= idle_cnt_d;
      fresh_cnt_q <= fresh_cnt_d;
      head_q      <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    baddr_q <= baddr_d;
    addr_q  <= addr_d;
    k_q     <= k_d;
    reqk_q  <= reqk_d;
    pk_q    <= pk_d;
    sb_q    <= sb_d;
    cur_q   <= cur_d;
    prev_q  <= prev_d;
    res_q   <= res_d;
  end

  // minblock memory: link, class, superblock and allocated mark per minblock
  always_ff @(posedge clk_i) begin
    if (a_we.link) begin
      mema[a_waddr].link <= a_wdata.link;
    end
    if (a_we.cls) begin
      mema[a_waddr].cls <= a_wdata.cls;
    end
    if (a_we.sbi) begin
      mema[a_waddr].sbi <= a_wdata.sbi;
    end
    if (a_we.alloc) begin
      mema[a_waddr].alloc <= a_wdata.alloc;
    end
    a_rdata_q <= mema[a_raddr];
  end

  // superblock memory: bytes in use and idle stack entry
  always_ff @(posedge clk_i) begin
    if (b_we.bytes) begin
      memb[b_waddr].bytes <= b_wdata.bytes;
    end
    if (b_we.idle) begin
      memb[b_waddr].idle <= b_wdata.idle;
    end
    b_rdata_q <= memb[b_raddr];
  end

  sba_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (out_load),
    .res_i      (res_q),
    .out_stall_i(out_stall_i),
    .ready_o    (out_ready),
    .out_valid_o(out_valid_o),
    .res_o      (out_res)
  );

  assign status_o              = out_res.status;
  assign granted_address_o     = out_res.gaddr;
  assign size_class_o          = out_res.sclass;
  assign superblock_released_o = out_res.released;

  `SBA_ASSERT_SAME(a_idle_bound, 1'b1, idle_cnt_q <= CW'(SUPERBLOCKS), "idle count overflow")
  `SBA_ASSERT_SAME(a_fresh_bound, 1'b1, fresh_cnt_q <= CW'(SUPERBLOCKS), "fresh count overflow")
  `SBA_ASSERT_SAME(a_split_order, state_q == S_SPLIT, k_q >= reqk_q, "split below request class")
  `SBA_ASSERT_NEXT(a_accept_starts, in_valid_i && !in_stall_o, state_q != S_IDLE, "beat not started")
  `SBA_ASSERT_NEXT(a_done_loads, (state_q == S_DONE) && out_ready, out_valid_o, "result not loaded")

endmodule

@@ rtl/sba_search.sv @@
// size class fit and smallest non-empty free list search
module sba_search import sba_pkg::*; #(
  parameter int KMAX           = 10,
  parameter int MINBLOCK_BYTES = 64
) (
  input  logic [REQ_W-1:0] req_i,
  input  logic [KMAX:0]    nonempty_i,
  output srch_t            srch_o
);

  localparam logic [31:0] MAXB = 32'(MINBLOCK_BYTES) << KMAX;

  always_comb begin
    logic [31:0] cb;
    srch_o           = '0;
    srch_o.too_large = 32'(req_i) > MAXB;
    for (int k = KMAX; k >= 0; k--) begin
      cb = 32'(MINBLOCK_BYTES) << k;
      if (32'(req_i) <= cb) begin
        srch_o.req_k = CLS_W'(k);
        if (nonempty_i[k]) begin
          srch_o.hit   = 1'b1;
          srch_o.hit_k = CLS_W'(k);
        end
      end
    end
  end

endmodule

@@ rtl/sba_out_reg.sv @@
// result register between the sequencer and the output channel
module sba_out_reg import sba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic out_stall_i,
  output logic ready_o,
  output logic out_valid_o,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign ready_o     = !valid_q || !out_stall_i;
  assign valid_d     = load_i || (valid_q && out_stall_i);
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

@@ tb/alloc_checker.sv @@
// checker: watches both channels, predicts each allocator result and compares it
module alloc_checker import sba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              mode_i,
  input  logic [REQ_W-1:0]  request_bytes_i,
  input  logic [ADDR_W-1:0] block_address_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [1:0]        status_i,
  input  logic [ADDR_W-1:0] granted_address_i,
  input  logic [SC_W-1:0]   size_class_i,
  input  logic              superblock_released_i,
  output int                errors_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSB   = 16;
  localparam int MPS   = 1024;
  localparam int TOTAL = NSB * MPS;
  localparam int TOPK  = 10;
  localparam int MINLG = 6;

  int unsigned next_blk [TOTAL];
  int unsigned blk_cls  [TOTAL];
  bit          blk_busy [TOTAL];
  int unsigned free_head[TOPK+1];
  int unsigned sb_bytes [NSB];
  int unsigned idle_sb  [NSB];
  int unsigned n_idle;
  int unsigned n_fresh;

  res_t expected_results[$];
  int   errors;
  int   pending;

  initial begin
    for (int i = 0; i < TOTAL; i++) begin
      next_blk[i] = 0;
      blk_cls[i]  = 0;
      blk_busy[i] = 0;
    end
    for (int k = 0; k <= TOPK; k++) free_head[k] = TOTAL;
    for (int s = 0; s < NSB; s++) begin
      sb_bytes[s] = 0;
      idle_sb[s]  = 0;
    end
    n_idle  = 0;
    n_fresh = 0;
    errors  = 0;
    pending = 0;
  end

  function automatic void purge_sb(int unsigned sb);
    int unsigned prev, cur, nxt;
    for (int k = 0; k <= TOPK; k++) begin
      prev = TOTAL;
      cur  = free_head[k];
      while (cur < TOTAL) begin
        nxt = next_blk[cur];
        if (cur / MPS == sb) begin
          if (prev == TOTAL) free_head[k] = nxt;
          else next_blk[prev] = nxt;
        end else begin
          prev = cur;
        end
        cur = nxt;
      end
    end
  endfunction

  function automatic res_t allocate_or_free(logic m, int unsigned req, int unsigned ba);
    res_t r;
    int unsigned found, addr, sb, k, b;
    r = '0;
    r.status = ST_OK;
    if (m == 1'b0) begin
      if (req > (64 << TOPK)) begin
        r.status = ST_TOO_LARGE;
      end else begin
        found = TOPK + 1;
        addr  = TOTAL;
        for (int j = 0; j <= TOPK; j++) begin
          if (found > TOPK && req <= (64 << j) && free_head[j] < TOTAL) found = j;
        end
        if (found <= TOPK) begin
          addr = free_head[found];
          free_head[found] = next_blk[addr];
        end else begin
          sb = NSB;
          if (n_idle > 0) begin
            n_idle--;
            sb = idle_sb[n_idle];
          end else if (n_fresh < NSB) begin
            sb = n_fresh;
            n_fresh++;
          end
          if (sb < NSB) begin
            for (int i = 0; i < MPS; i++) blk_busy[sb*MPS+i] = 0;
            addr  = sb * MPS;
            found = TOPK;
          end
        end
        if (addr >= TOTAL) begin
          r.status = ST_NOMEM;
        end else begin
          k = found;
          while (k > 0 && req <= ((64 << k) / 2)) begin
            k--;
            next_blk[addr + (1 << k)] = free_head[k];
            free_head[k] = addr + (1 << k);
          end
          blk_cls[addr]  = k;
          blk_busy[addr] = 1;
          sb_bytes[addr / MPS] += (64 << k);
          r.gaddr  = addr[ADDR_W-1:0];
          r.sclass = SC_W'(MINLG + k);
        end
      end
    end else begin
      if (ba >= TOTAL || !blk_busy[ba]) begin
        r.status = ST_BAD_FREE;
      end else begin
        k  = blk_cls[ba];
        sb = ba / MPS;
        b  = 64 << k;
        blk_busy[ba] = 0;
        next_blk[ba] = free_head[k];
        free_head[k] = ba;
        sb_bytes[sb] = (sb_bytes[sb] >= b) ? sb_bytes[sb] - b : 0;
        if (sb_bytes[sb] == 0) begin
          purge_sb(sb);
          if (n_idle < NSB) begin
            idle_sb[n_idle] = sb;
            n_idle++;
          end
          r.released = 1'b1;
        end
        r.sclass = SC_W'(MINLG + k);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && in_valid_i && !in_stall_i)
      expected_results.insert(expected_results.size(),
                              allocate_or_free(mode_i, request_bytes_i, block_address_i));
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected: status %0d addr %0d class %0d rel %0d",
                 $time, status_i, granted_address_i, size_class_i, superblock_released_i);
      end else begin
        want = expected_results.pop_front();
        if (want.status != status_e'(status_i)) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
        end
        if (want.gaddr != granted_address_i) begin
          errors++;
          $display("%0t: granted_address expected %0d actual %0d", $time, want.gaddr,
                   granted_address_i);
        end
        if (want.sclass != size_class_i) begin
          errors++;
          $display("%0t: size_class expected %0d actual %0d", $time, want.sclass, size_class_i);
        end
        if (want.released != superblock_released_i) begin
          errors++;
          $display("%0t: superblock_released expected %0d actual %0d", $time, want.released,
                   superblock_released_i);
        end
      end
    end
    pending = expected_results.size();
  end

  assign errors_o  = errors;
  assign pending_o = pending;
endmodule

@@ tb/tb.sv @@
// testbench top: clock, reset, allocate and free stimulus, verdict
module tb;
  import sba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 4000000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              mode_i = 1'b0;
  logic [REQ_W-1:0]  request_bytes_i = '0;
  logic [ADDR_W-1:0] block_address_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        status_o;
  logic [ADDR_W-1:0] granted_address_o;
  logic [SC_W-1:0]   size_class_o;
  logic              superblock_released_o;

  int errors, pending;
  int cycles = 0;
  bit calm = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int burst_left = 0;
  logic mode_sent[$];
  logic [ADDR_W-1:0] live_blocks[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  split_only_buddy_allocator i_dut (.*);

  alloc_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .mode_i, .request_bytes_i,
    .block_address_i, .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .granted_address_i(granted_address_o), .size_class_i(size_class_o),
    .superblock_released_i(superblock_released_o), .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // granted blocks are kept so that most frees hit a live block
  always @(posedge clk_i) begin
    logic m;
    if (rst_ni && out_valid_o && !out_stall_i && mode_sent.size() > 0) begin
      m = mode_sent.pop_front();
      if (m == 1'b0 && status_e'(status_o) == ST_OK)
        live_blocks.insert(live_blocks.size(), granted_address_o);
    end
  end

  always @(negedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_left = 400;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_beat(logic m, int unsigned req, int unsigned ba);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= m;
    request_bytes_i <= REQ_W'(req);
    block_address_i <= ADDR_W'(ba);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    mode_sent.insert(mode_sent.size(), m);
    @(negedge clk_i);
  endtask

  // stop offering beats and wait until every expected result has come
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic free_live();
    int idx;
    idx = $urandom_range(0, live_blocks.size() - 1);
    send_beat(1'b1, $urandom, live_blocks[idx]);
    live_blocks.delete(idx);
  endtask

  initial begin
    int unsigned pick;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // size extremes, oversize, bad free, then exhaustion of all superblocks
    send_beat(1'b0, 0, 0);
    send_beat(1'b0, 1, 0);
    send_beat(1'b0, 65, 0);
    send_beat(1'b0, 65537, 0);
    send_beat(1'b0, 131071, 16383);
    send_beat(1'b1, 0, 16383);
    send_beat(1'b1, 0, 0);
    send_beat(1'b1, 0, 0);
    for (int i = 0; i < 16; i++) send_beat(1'b0, 65536, 0);
    send_beat(1'b0, 64, 0);
    drain();
    while (live_blocks.size() > 0) free_live();
    drain();

    for (int n = 0; n < 950; n++) begin
      if (n == 300) hold_req = 1;
      if (n == 600) drain();
      if (n == 850) calm = 1;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_beat(1'b0, $urandom_range(65537, 131071), $urandom);
      end else if (pick < 8) begin
        send_beat(1'b1, $urandom, $urandom_range(0, 16383));
      end else if (live_blocks.size() > 0 &&
                   (pick < 45 || live_blocks.size() > 60)) begin
        free_live();
      end else if (pick < 70) begin
        send_beat(1'b0, $urandom_range(0, 1024), $urandom);
      end else if (pick < 90) begin
        send_beat(1'b0, $urandom_range(0, 8192), $urandom);
      end else begin
        send_beat(1'b0, $urandom_range(0, 65536), $urandom);
      end
    end

    drain();
    repeat (200) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
